// ===== rtl/core/mbps_pkg.sv =====
// mbps_pkg: shared constants, codes and types of the masked byte pattern scanner
// no dependencies; imported by every rtl/core module of the scanner
package mbps_pkg;

	localparam int PATTERN_MAX  = 64;
	localparam int OFFSET_WIDTH = 25;

	localparam int IDX_W   = $clog2(PATTERN_MAX);
	localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
	localparam int COUNT_W = OFFSET_WIDTH + 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// func codes of an input transaction
	localparam logic [1:0] FUNC_LOAD    = 2'd0;
	localparam logic [1:0] FUNC_SCAN    = 2'd1;
	localparam logic [1:0] FUNC_RESTART = 2'd2;

	typedef logic [PATTERN_MAX-1:0][7:0] byte_vec_t;

endpackage

// ===== rtl/core/mbps_match.sv =====
// mbps_match: compares the aligned byte window against the masked pattern
// depends on mbps_pkg
module mbps_match (
	input  mbps_pkg::byte_vec_t           window,
	input  mbps_pkg::byte_vec_t           pattern,
	input  mbps_pkg::byte_vec_t           mask,
	input  logic [mbps_pkg::LEN_W-1:0]    len,
	output logic                          hit
);
	import mbps_pkg::*;

	logic [PATTERN_MAX-1:0] mism;
	logic [LEN_W-1:0]       sel [PATTERN_MAX];

	// pattern position j lines up with window entry len-1-j (entry 0 is newest)
	always_comb begin
		for (int j = 0; j < PATTERN_MAX; j++) begin
			sel[j]  = len - LEN_W'(1) - LEN_W'(j);
			mism[j] = (LEN_W'(j) < len) &&
				((window[sel[j][IDX_W-1:0]] & mask[j]) != pattern[j]);
		end
	end

	assign hit = ~|mism;

endmodule

// ===== rtl/core/masked_byte_pattern_scanner.sv =====
// masked_byte_pattern_scanner: top level, input stage, scan state and result register
// depends on mbps_pkg and mbps_match
//
// usage
//   input channel (in_valid/in_ready) carries one transaction per item: func selects
//   a pattern/mask load, a scan of one data byte, or a restart of the scan
//   output channel (out_valid/out_ready) carries at most one result per buffer:
//   found=1 with the start offset of the first matching window, or found=0 on the
//   byte marked last when nothing matched
//   cfg_wr_en/cfg_wr_data write pattern_length, unchecked; the user must write it only while the block is idle
// flow and throughput
//   an accepted transaction is registered in the input stage and moves into the output
//   register once that register is free or draining; out_valid rises when a scan
//   transaction there gives a result; one transaction per cycle sustained while no
//   result waits for out_ready; the whole window compare is one combinational pass
//   between the input stage and the result register
// stalls
//   while a result waits for out_ready, the input stage holds its transaction and
//   in_ready drops once that stage is full; nothing is lost or reordered
// reset
//   arst_n clears the scan counter, the match flag, both valid bits, and sets
//   pattern_length to 40; pattern and mask entries are undefined until loaded
module masked_byte_pattern_scanner (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [6:0]                          cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          func,
	input  logic [5:0]                          pattern_index,
	input  logic [7:0]                          pattern_byte,
	input  logic [7:0]                          mask_byte,
	input  logic [7:0]                          data_byte,
	input  logic                                last,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                found,
	output logic [mbps_pkg::OFFSET_WIDTH-1:0]   match_offset
);
	import mbps_pkg::*;

	// input stage
	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [5:0]  index_s1;
	logic [7:0]  pat_s1;
	logic [7:0]  mask_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        fire_s1;

	// scan state
	logic [LEN_W-1:0]   len_q;
	byte_vec_t          pattern_q;
	byte_vec_t          mask_q;
	byte_vec_t          window_q;
	logic [COUNT_W-1:0] count_q;
	logic               reported_q;

	// result register
	logic                    out_valid_q;
	logic                    found_q;
	logic [OFFSET_WIDTH-1:0] offset_q;

	// next-state and match signals
	byte_vec_t          window_next;
	logic [COUNT_W-1:0] count_next;
	logic [COUNT_W-1:0] start;
	logic               hit;
	logic               is_scan;
	logic               match;
	logic               res_valid;

	// clamp the written length into 1..PATTERN_MAX
	function automatic logic [LEN_W-1:0] clamp_len(input logic [6:0] v);
		logic [LEN_W-1:0] r;
		if (v == 7'd0)
			r = LEN_W'(1);
		else if (32'(v) > PATTERN_MAX)
			r = LEN_W'(PATTERN_MAX);
		else
			r = LEN_W'(v);
		return r;
	endfunction

	// input stage moves on whenever the result register is free or draining
	assign fire_s1  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1  <= func;
			index_s1 <= pattern_index;
			pat_s1   <= pattern_byte;
			mask_s1  <= mask_byte;
			data_s1  <= data_byte;
			last_s1  <= last;
		end
	end

	// window with the new byte shifted in at entry 0
	assign window_next = {window_q[PATTERN_MAX-2:0], data_s1};
	assign count_next  = (count_q != COUNT_MAX) ? count_q + COUNT_W'(1) : count_q;
	assign start       = count_next - COUNT_W'(len_q);

	mbps_match u_match (
		.window  (window_next),
		.pattern (pattern_q),
		.mask    (mask_q),
		.len     (len_q),
		.hit     (hit)
	);

	// a window counts only once complete, before saturation, and with an offset
	// that fits the output field
	assign is_scan   = (func_s1 == FUNC_SCAN);
	assign match     = is_scan && !reported_q && hit
		&& (count_next >= COUNT_W'(len_q))
		&& (count_next != COUNT_MAX)
		&& !start[COUNT_W-1];
	assign res_valid = match || (is_scan && last_s1 && !reported_q);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(40);
		end else if (cfg_wr_en) begin
			len_q <= clamp_len(cfg_wr_data);
		end
	end

	// pattern and mask entries, no reset
	always_ff @(posedge clk) begin
		if (fire_s1 && func_s1 == FUNC_LOAD && 32'(index_s1) < PATTERN_MAX) begin
			pattern_q[index_s1[IDX_W-1:0]] <= pat_s1;
			mask_q[index_s1[IDX_W-1:0]]    <= mask_s1;
		end
	end

	// window bytes older than the count are never compared, so no clearing
	always_ff @(posedge clk) begin
		if (fire_s1 && is_scan) begin
			window_q <= window_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			reported_q <= 1'b0;
		end else if (fire_s1) begin
			case (func_s1)
				FUNC_RESTART: begin
					count_q    <= '0;
					reported_q <= 1'b0;
				end
				FUNC_SCAN: begin
					if (last_s1) begin
						// end of buffer restarts the scan by itself
						count_q    <= '0;
						reported_q <= 1'b0;
					end else begin
						count_q <= count_next;
						if (match)
							reported_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res_valid) begin
			found_q  <= match;
			offset_q <= match ? start[OFFSET_WIDTH-1:0] : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign match_offset = offset_q;

endmodule

// ===== rtl/core/mbps_checker.sv =====
// mbps_checker: port-level assertions for the masked byte pattern scanner, with bind
// depends on mbps_pkg; attaches to masked_byte_pattern_scanner
module mbps_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [1:0]                          func,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic                                found,
	input  logic [mbps_pkg::OFFSET_WIDTH-1:0]   match_offset
);
	import mbps_pkg::*;

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_offset))
		else $error("result changed while stalled");

	// a not-found result carries offset zero
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_offset == '0)
		else $error("not-found result with nonzero offset");

	// a fresh result follows an accepted scan transaction
	a_res_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && func == FUNC_SCAN, 2))
		else $error("result without a scan transaction two cycles earlier");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.func         (func),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.found        (found),
	.match_offset (match_offset)
);
